// ===== rtl/crtc_update_address_video_store_core_assert.svh =====
// Assertion macros shared by the checker of the update-address video store
`ifndef CRTC_UPDATE_ADDRESS_VIDEO_STORE_CORE_ASSERT_SVH
`define CRTC_UPDATE_ADDRESS_VIDEO_STORE_CORE_ASSERT_SVH

// Check that cons holds in the cycle after ante, outside reset
`define CRTCUA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// Check that cons holds in the cycle after ante, reset included
`define CRTCUA_ASSERT_NEXT_ALWAYS(lbl, clk, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/crtcua_pkg.sv =====
// Types and constants of the update-address video store
package crtcua_pkg;

  localparam int ADDR_W      = 16;
  localparam int BYTE_W      = 8;
  localparam int TILE_W      = 10;
  localparam int CODE_W      = 12;
  localparam int COLOUR_W    = 4;
  localparam int IN_TDATA_W  = 32;
  localparam int OUT_TDATA_W = 32;

  // Input item field positions in in_tdata
  localparam int CMD_LSB  = 0;
  localparam int DATA_LSB = 2;
  localparam int ATTR_LSB = 10;
  localparam int TILE_LSB = 18;

  // Register numbers a select may latch
  localparam logic [BYTE_W-1:0] REG_ADDR_HIGH = 8'h12;
  localparam logic [BYTE_W-1:0] REG_ADDR_LOW  = 8'h13;
  localparam logic [BYTE_W-1:0] REG_DUMMY     = 8'h1f;

  typedef enum logic [1:0] {
    CMD_SELECT     = 2'd0,
    CMD_ADDR_WRITE = 2'd1,
    CMD_DISP_WRITE = 2'd2,
    CMD_TILE_READ  = 2'd3
  } cmd_code_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_MUL,
    ST_SUB,
    ST_READ
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic accept;
    logic clear_en;
    logic idx_load;
    logic read_load;
  } ctrl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic clear_last;
    logic out_valid;
  } dp_status_t;

endpackage

// ===== rtl/crtc_update_address_video_store_core.sv =====
// Top level of the transparent update-address video store
// One item at a time, one result per item. After reset the block zeroes the
// store, one entry a cycle, and takes no item until the pass is done. A
// register select or a display write ends when taken; a tile read passes the
// registered store read port and ST_READ; an address write, ST_MUL and ST_SUB:
// the new address is reduced modulo STORE_DEPTH by a reciprocal multiply, then
// a multiply and subtract with one correction, to give the store index. The
// result sits in an output register; while it waits to be delivered the input
// is held off, and the next item can be taken in the cycle it is delivered.
module crtc_update_address_video_store_core #(
  parameter int STORE_DEPTH = 1024
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // [1:0] command, [9:2] data_byte, [17:10] attribute_byte, [27:18] tile_number
  input  logic [crtcua_pkg::IN_TDATA_W-1:0]   in_tdata,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // [11:0] tile_code, [15:12] tile_colour, [31:16] update_address
  output logic [crtcua_pkg::OUT_TDATA_W-1:0]  out_tdata
);

  crtcua_pkg::ctrl_cmd_t  cmd;
  crtcua_pkg::dp_status_t status;

  crtcua_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .command    (in_tdata[crtcua_pkg::CMD_LSB +: 2]),
    .out_tready (out_tready),
    .status     (status),
    .in_tready  (in_tready),
    .cmd        (cmd)
  );

  crtcua_datapath #(
    .STORE_DEPTH (STORE_DEPTH)
  ) u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .out_tready (out_tready),
    .cmd        (cmd),
    .status     (status),
    .out_tvalid (out_tvalid),
    .out_tdata  (out_tdata)
  );

endmodule

// ===== rtl/crtcua_store.sv =====
// Character and attribute store: one write port, one registered read port
module crtcua_store #(
  parameter int DEPTH = 1024,
  parameter int IDX_W = 10
) (
  input  logic             clk,
  input  logic             we,
  input  logic [IDX_W-1:0] waddr,
  input  logic [15:0]      wdata,
  input  logic [IDX_W-1:0] raddr,
  output logic [15:0]      rdata
);

  logic [15:0] mem [DEPTH];
  logic [15:0] rdata_r;

  // Write attribute and character side by side
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Register read data
  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/crtcua_datapath.sv =====
// Datapath: address registers, store index, modulo unit, store and output register
module crtcua_datapath #(
  parameter int STORE_DEPTH = 1024
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic [crtcua_pkg::IN_TDATA_W-1:0]    in_tdata,
  input  logic                                 out_tready,
  input  crtcua_pkg::ctrl_cmd_t                cmd,
  output crtcua_pkg::dp_status_t               status,
  output logic                                 out_tvalid,
  output logic [crtcua_pkg::OUT_TDATA_W-1:0]   out_tdata
);

  localparam int ADDR_W  = crtcua_pkg::ADDR_W;
  localparam int BYTE_W  = crtcua_pkg::BYTE_W;
  localparam int IDX_W   = $clog2(STORE_DEPTH);
  localparam int SHIFT   = 2 * ADDR_W;
  localparam longint unsigned RECIP = (64'd1 << SHIFT) / STORE_DEPTH;
  localparam int RECIP_W = $clog2(RECIP + 1);
  localparam int PROD_W  = ADDR_W + RECIP_W;
  localparam int Q_MAX   = ((1 << ADDR_W) - 1) / STORE_DEPTH;
  localparam int Q_W     = $clog2(Q_MAX + 2);
  localparam logic [ADDR_W:0]    DEPTH_X  = (ADDR_W + 1)'(STORE_DEPTH);
  localparam logic [IDX_W:0]     DEPTH_I  = (IDX_W + 1)'(STORE_DEPTH);
  localparam logic [IDX_W-1:0]   LAST_IDX = IDX_W'(STORE_DEPTH - 1);

  // Input fields
  crtcua_pkg::cmd_code_t         cmd_code;
  logic [BYTE_W-1:0]             data_byte;
  logic [BYTE_W-1:0]             attr_byte;
  logic [crtcua_pkg::TILE_W-1:0] tile_number;

  assign cmd_code    = crtcua_pkg::cmd_code_t'(in_tdata[crtcua_pkg::CMD_LSB +: 2]);
  assign data_byte   = in_tdata[crtcua_pkg::DATA_LSB +: BYTE_W];
  assign attr_byte   = in_tdata[crtcua_pkg::ATTR_LSB +: BYTE_W];
  assign tile_number = in_tdata[crtcua_pkg::TILE_LSB +: crtcua_pkg::TILE_W];

  logic [BYTE_W-1:0] sel_r, sel_nxt;
  logic [BYTE_W-1:0] hi_r, hi_nxt;
  logic [BYTE_W-1:0] lo_r, lo_nxt;
  logic [IDX_W-1:0]  idx_r, idx_nxt;
  logic [IDX_W-1:0]  clr_cnt_r, clr_cnt_nxt;
  logic [PROD_W-1:0] prod_r;

  logic [ADDR_W-1:0] addr;
  logic [ADDR_W-1:0] addr_inc;
  logic [IDX_W:0]    idx_inc;
  logic [Q_W-1:0]    quot;
  logic [ADDR_W:0]   quot_d;
  logic [ADDR_W:0]   rem_raw;
  logic [IDX_W-1:0]  rem_idx;
  logic [ADDR_W:0]   tile_x;
  logic [IDX_W-1:0]  tile_idx;
  logic              disp_we;

  assign addr     = {hi_r, lo_r};
  assign addr_inc = addr + ADDR_W'(1);
  assign idx_inc  = {1'b0, idx_r} + (IDX_W + 1)'(1);
  assign disp_we  = cmd.accept && (cmd_code == crtcua_pkg::CMD_DISP_WRITE);

  // Reduce the address modulo the depth: reciprocal estimate, then one correction
  always_ff @(posedge clk) begin
    prod_r <= PROD_W'(addr) * PROD_W'(RECIP);
  end

  assign quot    = Q_W'(prod_r >> SHIFT);
  assign quot_d  = (ADDR_W + 1)'(quot) * DEPTH_X;
  assign rem_raw = {1'b0, addr} - quot_d;
  assign rem_idx = (rem_raw >= DEPTH_X) ? IDX_W'(rem_raw - DEPTH_X) : IDX_W'(rem_raw);

  // Tile number lies below twice the depth
  assign tile_x   = (ADDR_W + 1)'(tile_number);
  assign tile_idx = (tile_x >= DEPTH_X) ? IDX_W'(tile_x - DEPTH_X) : IDX_W'(tile_x);

  // Update register select, address bytes and store index
  always_comb begin
    sel_nxt     = sel_r;
    hi_nxt      = hi_r;
    lo_nxt      = lo_r;
    idx_nxt     = idx_r;
    clr_cnt_nxt = clr_cnt_r;
    if (cmd.clear_en) begin
      clr_cnt_nxt = clr_cnt_r + IDX_W'(1);
    end
    if (cmd.idx_load) begin
      idx_nxt = rem_idx;
    end
    if (cmd.accept) begin
      case (cmd_code)
        crtcua_pkg::CMD_SELECT: begin
          if (data_byte == crtcua_pkg::REG_ADDR_HIGH || data_byte == crtcua_pkg::REG_ADDR_LOW ||
              data_byte == crtcua_pkg::REG_DUMMY) begin
            sel_nxt = data_byte;
          end
        end
        crtcua_pkg::CMD_ADDR_WRITE: begin
          if (sel_r == crtcua_pkg::REG_ADDR_HIGH) begin
            hi_nxt = data_byte;
          end else if (sel_r == crtcua_pkg::REG_ADDR_LOW) begin
            lo_nxt = data_byte;
          end
        end
        crtcua_pkg::CMD_DISP_WRITE: begin
          {hi_nxt, lo_nxt} = addr_inc;
          if (addr_inc == '0 || idx_inc == DEPTH_I) begin
            idx_nxt = '0;
          end else begin
            idx_nxt = idx_inc[IDX_W-1:0];
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sel_r     <= '0;
      hi_r      <= '0;
      lo_r      <= '0;
      idx_r     <= '0;
      clr_cnt_r <= '0;
    end else begin
      sel_r     <= sel_nxt;
      hi_r      <= hi_nxt;
      lo_r      <= lo_nxt;
      idx_r     <= idx_nxt;
      clr_cnt_r <= clr_cnt_nxt;
    end
  end

  // Store: clearing pass after reset, display writes, tile reads
  logic [15:0] rd_data;

  crtcua_store #(
    .DEPTH (STORE_DEPTH),
    .IDX_W (IDX_W)
  ) u_store (
    .clk   (clk),
    .we    (cmd.clear_en || disp_we),
    .waddr (cmd.clear_en ? clr_cnt_r : idx_r),
    .wdata (cmd.clear_en ? 16'd0 : {attr_byte, data_byte}),
    .raddr (tile_idx),
    .rdata (rd_data)
  );

  // Output register
  logic                            out_valid_r, out_valid_nxt;
  logic [crtcua_pkg::CODE_W-1:0]   out_code_r, out_code_nxt;
  logic [crtcua_pkg::COLOUR_W-1:0] out_colour_r, out_colour_nxt;
  logic [ADDR_W-1:0]               out_addr_r, out_addr_nxt;

  always_comb begin
    out_valid_nxt  = out_valid_r && !out_tready;
    out_code_nxt   = out_code_r;
    out_colour_nxt = out_colour_r;
    out_addr_nxt   = out_addr_r;
    if (cmd.accept && (cmd_code == crtcua_pkg::CMD_SELECT ||
                       cmd_code == crtcua_pkg::CMD_DISP_WRITE)) begin
      out_valid_nxt  = 1'b1;
      out_code_nxt   = '0;
      out_colour_nxt = '0;
      out_addr_nxt   = {hi_nxt, lo_nxt};
    end else if (cmd.idx_load) begin
      out_valid_nxt  = 1'b1;
      out_code_nxt   = '0;
      out_colour_nxt = '0;
      out_addr_nxt   = addr;
    end else if (cmd.read_load) begin
      out_valid_nxt  = 1'b1;
      out_code_nxt   = {rd_data[11:8], rd_data[7:0]};
      out_colour_nxt = rd_data[15:12];
      out_addr_nxt   = addr;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_code_r   <= out_code_nxt;
    out_colour_r <= out_colour_nxt;
    out_addr_r   <= out_addr_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_addr_r, out_colour_r, out_code_r};

  assign status.clear_last = (clr_cnt_r == LAST_IDX);
  assign status.out_valid  = out_valid_r;

endmodule

// ===== rtl/crtcua_ctrl.sv =====
// Controller: clearing pass, item acceptance and multi-cycle command sequencing
module crtcua_ctrl (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  input  logic [1:0]             command,
  input  logic                   out_tready,
  input  crtcua_pkg::dp_status_t status,
  output logic                   in_tready,
  output crtcua_pkg::ctrl_cmd_t  cmd
);

  crtcua_pkg::state_t    state_r, state_nxt;
  crtcua_pkg::cmd_code_t cmd_code;
  logic                  ready;
  logic                  accept;

  assign cmd_code = crtcua_pkg::cmd_code_t'(command);
  assign ready    = (state_r == crtcua_pkg::ST_IDLE) && (!status.out_valid || out_tready);
  assign accept   = ready && in_tvalid;

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      crtcua_pkg::ST_CLEAR: begin
        if (status.clear_last) begin
          state_nxt = crtcua_pkg::ST_IDLE;
        end
      end
      crtcua_pkg::ST_IDLE: begin
        if (accept) begin
          case (cmd_code)
            crtcua_pkg::CMD_ADDR_WRITE: state_nxt = crtcua_pkg::ST_MUL;
            crtcua_pkg::CMD_TILE_READ:  state_nxt = crtcua_pkg::ST_READ;
            default:                    state_nxt = crtcua_pkg::ST_IDLE;
          endcase
        end
      end
      crtcua_pkg::ST_MUL:  state_nxt = crtcua_pkg::ST_SUB;
      crtcua_pkg::ST_SUB:  state_nxt = crtcua_pkg::ST_IDLE;
      crtcua_pkg::ST_READ: state_nxt = crtcua_pkg::ST_IDLE;
      default:             state_nxt = crtcua_pkg::ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= crtcua_pkg::ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Outputs
  always_comb begin
    in_tready     = ready;
    cmd.accept    = accept;
    cmd.clear_en  = (state_r == crtcua_pkg::ST_CLEAR);
    cmd.idx_load  = (state_r == crtcua_pkg::ST_SUB);
    cmd.read_load = (state_r == crtcua_pkg::ST_READ);
  end

endmodule

// ===== rtl/crtcua_checker.sv =====
// Port-level checker for the update-address video store, bound to the top level
`include "crtc_update_address_video_store_core_assert.svh"

module crtcua_checker (
  input logic                               clk,
  input logic                               rst_n,
  input logic                               in_tvalid,
  input logic                               in_tready,
  input logic [crtcua_pkg::IN_TDATA_W-1:0]  in_tdata,
  input logic                               out_tvalid,
  input logic                               out_tready,
  input logic [crtcua_pkg::OUT_TDATA_W-1:0] out_tdata
);

  logic in_acc;
  logic short_cmd;
  logic long_cmd;

  assign in_acc    = in_tvalid && in_tready;
  assign short_cmd = (in_tdata[1:0] == crtcua_pkg::CMD_SELECT) ||
                     (in_tdata[1:0] == crtcua_pkg::CMD_DISP_WRITE);
  assign long_cmd  = (in_tdata[1:0] == crtcua_pkg::CMD_ADDR_WRITE) ||
                     (in_tdata[1:0] == crtcua_pkg::CMD_TILE_READ);

  // Stalled result holds
  `CRTCUA_ASSERT_NEXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata), "stalled result changed")

  // Clearing pass blocks items right after reset
  `CRTCUA_ASSERT_NEXT_ALWAYS(a_clear_after_reset, clk, !rst_n, !in_tready, "item taken during clearing pass")

  // Select and display write commands show their result on the next cycle
  `CRTCUA_ASSERT_NEXT(a_short_result, clk, rst_n, in_acc && short_cmd, out_tvalid, "select or display write gave no result")

  // Multi-cycle commands hold off the next item
  `CRTCUA_ASSERT_NEXT(a_long_busy, clk, rst_n, in_acc && long_cmd, !in_tready, "item taken while address or tile command busy")

endmodule

bind crtc_update_address_video_store_core crtcua_checker u_checker (.*);
